[rtl/core/tcw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = COLUMNS * ROWS;
    localparam int LAST_CELL = CELLS - 1;
    localparam int SCROLL_AT = COLUMNS * (ROWS - 1);

    // widths
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CW     = ADDR_W + 1;
    localparam int MODE_W = 3;
    localparam int CHAR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // width of column + row * COLUMNS before saturation
    localparam int PIN_W = $clog2((2 ** COL_W - 1) + (2 ** ROW_W - 1) * COLUMNS + 1);
    localparam int PW    = ((PIN_W > CW) ? PIN_W : CW) + 1;

    // reciprocal for the row split: quotient is low by at most one
    localparam int SPLIT_SH = ADDR_W + 1;
    localparam int SPLIT_K  = (2 ** SPLIT_SH) / COLUMNS;
    localparam int K_W      = ADDR_W + 2;
    localparam int PROD_W   = ADDR_W + K_W;
    localparam int Q_W      = PROD_W - SPLIT_SH;

    // cell and control codes
    localparam logic [CELL_W-1:0] BLANK   = 16'h0f20;
    localparam logic [CHAR_W-1:0] CODE_BS = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_NL = 8'h0a;
    localparam logic [CHAR_W-1:0] CODE_CR = 8'h0d;

    // operation modes
    localparam logic [MODE_W-1:0] MODE_CHAR  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_AT    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_FOLLOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_CODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_CODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_CODE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_CODE     = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
    } t_in;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [POS_W-1:0]  hw_cursor_pos;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
    } t_out;

    typedef struct packed {
        logic [7:0]        text_color;
        logic              cursor_follow;
        logic [CHAR_W-1:0] left_code;
        logic [CHAR_W-1:0] right_code;
        logic [CHAR_W-1:0] up_code;
        logic [CHAR_W-1:0] down_code;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0] cursor;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [CELL_W-1:0] cell_val;
        logic              scroll;
    } t_char_res;

endpackage

`default_nettype wire

[rtl/core/tcw_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/tcw_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcw_cfg import tcw_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_cfg_ready,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    // register file, writes to unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.text_color    <= 8'd15;
            r_cfg.cursor_follow <= 1'b1;
            r_cfg.left_code     <= 8'd128;
            r_cfg.right_code    <= 8'd129;
            r_cfg.up_code       <= 8'd130;
            r_cfg.down_code     <= 8'd131;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TEXT_COLOR:    r_cfg.text_color    <= i_cfg_data;
                CFG_CURSOR_FOLLOW: r_cfg.cursor_follow <= i_cfg_data[0];
                CFG_LEFT_CODE:     r_cfg.left_code     <= i_cfg_data;
                CFG_RIGHT_CODE:    r_cfg.right_code    <= i_cfg_data;
                CFG_UP_CODE:       r_cfg.up_code       <= i_cfg_data;
                CFG_DOWN_CODE:     r_cfg.down_code     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

`default_nettype wire

[rtl/core/tcw_rowsplit.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcw_rowsplit import tcw_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic [ADDR_W-1:0] i_idx,
    output logic      [ADDR_W-1:0] o_row_start
);

    logic [PROD_W-1:0] prod;
    logic [ADDR_W-1:0] r_idx;
    logic [Q_W-1:0]    r_quot;
    logic [CW-1:0]     base;
    logic [CW-1:0]     rem;
    logic [CW-1:0]     start;

    // quotient estimate by reciprocal multiply, registered
    assign prod = PROD_W'(i_idx) * PROD_W'(SPLIT_K);

    always_ff @(posedge i_clk) begin
        r_idx  <= i_idx;
        r_quot <= prod[PROD_W-1:SPLIT_SH];
    end

    // one correction step when the estimate is one row short
    always_comb begin
        base  = CW'(r_quot) * CW'(COLUMNS);
        rem   = CW'(r_idx) - base;
        start = (rem >= CW'(COLUMNS)) ? base + CW'(COLUMNS) : base;
    end

    assign o_row_start = start[ADDR_W-1:0];

endmodule

`default_nettype wire

[rtl/core/tcw_char.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcw_char import tcw_pkg::*; (
    input  wire logic [ADDR_W-1:0] i_work,
    input  wire logic [ADDR_W-1:0] i_row_start,
    input  wire logic [CHAR_W-1:0] i_code,
    input  wire t_cfg              i_cfg,
    output t_char_res              o_res
);

    logic [CW-1:0] w;
    logic [CW-1:0] rs;
    logic [CW-1:0] dec1;
    logic [CW-1:0] dec_row;
    logic [CW-1:0] inc1;
    logic [CW-1:0] inc_row;
    logic [CW-1:0] next_row;
    logic [CW-1:0] sum1;
    logic [CW-1:0] sum_row;
    logic [CW-1:0] sum_nl;

    // saturating cursor moves
    always_comb begin
        w        = CW'(i_work);
        rs       = CW'(i_row_start);
        sum1     = w + CW'(1);
        sum_row  = w + CW'(COLUMNS);
        sum_nl   = rs + CW'(COLUMNS);
        dec1     = (w != '0) ? w - CW'(1) : '0;
        dec_row  = (w > CW'(COLUMNS)) ? w - CW'(COLUMNS) : '0;
        inc1     = (sum1 > CW'(LAST_CELL)) ? CW'(LAST_CELL) : sum1;
        inc_row  = (sum_row > CW'(LAST_CELL)) ? CW'(LAST_CELL) : sum_row;
        next_row = (sum_nl > CW'(LAST_CELL)) ? CW'(LAST_CELL) : sum_nl;
    end

    // control codes first, then arrows, then a plain character
    always_comb begin
        o_res.cursor   = i_work;
        o_res.we       = 1'b0;
        o_res.waddr    = i_work;
        o_res.wdata    = BLANK;
        o_res.cell_val = '0;
        o_res.scroll   = 1'b0;
        if (i_code == CODE_BS) begin
            o_res.cursor   = dec1[ADDR_W-1:0];
            o_res.we       = 1'b1;
            o_res.waddr    = dec1[ADDR_W-1:0];
            o_res.cell_val = BLANK;
        end else if (i_code == CODE_NL) begin
            o_res.cursor = next_row[ADDR_W-1:0];
        end else if (i_code == CODE_CR) begin
            o_res.cursor = i_row_start;
        end else if (i_code == i_cfg.left_code) begin
            o_res.cursor = dec1[ADDR_W-1:0];
        end else if (i_code == i_cfg.right_code) begin
            o_res.cursor = inc1[ADDR_W-1:0];
        end else if (i_code == i_cfg.up_code) begin
            o_res.cursor = dec_row[ADDR_W-1:0];
        end else if (i_code == i_cfg.down_code) begin
            o_res.cursor = inc_row[ADDR_W-1:0];
        end else begin
            o_res.we       = 1'b1;
            o_res.wdata    = {i_cfg.text_color, i_code};
            o_res.cell_val = {i_cfg.text_color, i_code};
            // landing in the last row scrolls and pulls the cursor up a row
            if (inc1 >= CW'(SCROLL_AT)) begin
                o_res.scroll = 1'b1;
                o_res.cursor = ADDR_W'(inc1 - CW'(COLUMNS));
            end else begin
                o_res.cursor = inc1[ADDR_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/text_console_cell_writer.sv]
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+--------------------------------
// in       | to block  | i_in_valid / o_in_stall    | i_in_data   (mode, char, pos)
// out      | from block| o_out_valid / i_out_stall  | o_out_data  (cursor, hw, cell)
// cfg      | to block  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item at a time through the cell memory: a character passes the states position, row
// split, write and result before its result loads, a read cell position, read and result,
// set cursor position and result, and the next accept comes from idle. A scroll or a clear
// sweeps the cell memory one cell a cycle. After reset the same sweep blanks the memory;
// o_in_stall is high for the whole sweep while configuration writes are taken. A result held
// by i_out_stall sits in the output register while the next item is worked on.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cell_writer import tcw_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out                       o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_POS,
        S_SPLIT,
        S_EXEC,
        S_READ,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    t_in               r_item, n_item;
    logic [ADDR_W-1:0] r_cursor, n_cursor;
    logic [ADDR_W-1:0] r_hw, n_hw;
    logic [ADDR_W-1:0] r_work, n_work;
    logic [CELL_W-1:0] r_cell, n_cell;
    logic              r_scr, n_scr;
    logic [ADDR_W-1:0] r_sweep, n_sweep;
    logic              r_clr, n_clr;
    logic              r_wr_valid, n_wr_valid;
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;
    logic              r_wr_blank, n_wr_blank;
    t_out              r_out, n_out;
    logic              r_out_valid, n_out_valid;

    t_cfg              cfg;
    t_char_res         char_res;
    logic [ADDR_W-1:0] row_start;
    logic [PW-1:0]     pos_raw;
    logic [ADDR_W-1:0] pos;
    logic [ADDR_W-1:0] sweep_rd;
    logic [ADDR_W-1:0] final_cursor;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    tcw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tcw_rowsplit u_rowsplit (
        .i_clk       (i_clk),
        .i_idx       (r_work),
        .o_row_start (row_start)
    );

    tcw_char u_char (
        .i_work      (r_work),
        .i_row_start (row_start),
        .i_code      (r_item.char_code),
        .i_cfg       (cfg),
        .o_res       (char_res)
    );

    // cell index of the transaction position, saturated to the last cell
    always_comb begin
        pos_raw = PW'(r_item.column) + PW'(r_item.row) * PW'(COLUMNS);
        pos     = (pos_raw > PW'(LAST_CELL)) ? ADDR_W'(LAST_CELL) : pos_raw[ADDR_W-1:0];
    end

    // sweep reads one row ahead of the cell it writes
    assign sweep_rd     = ADDR_W'(CW'(r_sweep) + CW'(COLUMNS));
    assign final_cursor = (r_item.mode == MODE_AT) ? r_cursor : char_res.cursor;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_cursor    = r_cursor;
        n_hw        = r_hw;
        n_work      = r_work;
        n_cell      = r_cell;
        n_scr       = r_scr;
        n_sweep     = r_sweep;
        n_clr       = r_clr;
        n_wr_valid  = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_wr_blank  = r_wr_blank;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // pending sweep write lands in the cycle after its read
        ram_we    = r_wr_valid;
        ram_waddr = r_wr_addr;
        ram_wdata = r_wr_blank ? BLANK : ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = pos;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT, S_SWEEP: begin
                ram_re     = 1'b1;
                ram_raddr  = sweep_rd;
                n_wr_valid = 1'b1;
                n_wr_addr  = r_sweep;
                n_wr_blank = (r_state == S_INIT) || r_clr ||
                             (r_sweep >= ADDR_W'(SCROLL_AT));
                if (r_sweep == ADDR_W'(LAST_CELL)) begin
                    n_sweep = '0;
                    n_state = (r_state == S_INIT) ? S_IDLE : S_DONE;
                end else begin
                    n_sweep = r_sweep + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_cell  = '0;
                    n_scr   = 1'b0;
                    n_state = S_POS;
                end
            end
            S_POS: begin
                case (r_item.mode)
                    MODE_CHAR: begin
                        n_work  = r_cursor;
                        n_state = S_SPLIT;
                    end
                    MODE_AT: begin
                        n_work  = pos;
                        n_state = S_SPLIT;
                    end
                    MODE_SET: begin
                        n_cursor = pos;
                        n_state  = S_DONE;
                    end
                    MODE_CLEAR: begin
                        n_cursor = '0;
                        n_sweep  = '0;
                        n_clr    = 1'b1;
                        n_state  = S_SWEEP;
                    end
                    MODE_READ: begin
                        ram_re  = 1'b1;
                        n_state = S_READ;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SPLIT: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (char_res.we) begin
                    ram_we    = 1'b1;
                    ram_waddr = char_res.waddr;
                    ram_wdata = char_res.wdata;
                end
                n_cell   = char_res.cell_val;
                n_scr    = char_res.scroll;
                n_cursor = final_cursor;
                if (cfg.cursor_follow) begin
                    n_hw = final_cursor;
                end
                if (char_res.scroll) begin
                    n_sweep = '0;
                    n_clr   = 1'b0;
                    n_state = S_SWEEP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_cell  = ram_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.cursor_pos    = POS_W'(r_cursor);
                    n_out.hw_cursor_pos = POS_W'(r_hw);
                    n_out.cell_value    = r_cell;
                    n_out.scrolled      = r_scr;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cursor    <= '0;
            r_hw        <= '0;
            r_sweep     <= '0;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_item      <= n_item;
            r_cursor    <= n_cursor;
            r_hw        <= n_hw;
            r_work      <= n_work;
            r_cell      <= n_cell;
            r_scr       <= n_scr;
            r_sweep     <= n_sweep;
            r_clr       <= n_clr;
            r_wr_valid  <= n_wr_valid;
            r_wr_addr   <= n_wr_addr;
            r_wr_blank  <= n_wr_blank;
            r_out       <= n_out;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[rtl/core/tcw_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker import tcw_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire t_out                  o_out_data
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // one transaction in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction taken while one is in work");

    // cursor positions stay inside the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.cursor_pos <= POS_W'(LAST_CELL)) &&
                        (o_out_data.hw_cursor_pos <= POS_W'(LAST_CELL)))
        else $error("cursor position beyond last cell");

endmodule

bind text_console_cell_writer tcw_checker u_tcw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

[test/text_console_cell_writer_tb.sv]
`timescale 1ns / 1ps

module text_console_cell_writer_tb;
    import tcw_pkg::*;

    // modes the block leaves unused
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam int NUM_REGS     = 6;
    localparam int PHASE_ITEMS  = 75;
    localparam int QUIET_LIMIT  = 20000;
    localparam int MAX_REPORTS  = 100;
    localparam int TAIL_CYCLES  = 50;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_style;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // shadow of the console state
    logic [CELL_W-1:0] shadow_cells [CELLS];
    int unsigned shadow_cursor = 0;
    int unsigned shadow_hw = 0;
    t_cfg regs_now = '{text_color: 8'd15, cursor_follow: 1'b1, left_code: 8'd128,
                       right_code: 8'd129, up_code: 8'd130, down_code: 8'd131};

    t_out expected_screen_q[$];
    t_out want;
    int err_count = 0;
    int idle_cycles = 0;
    bit sender_gaps = 1'b1;
    bit in_busy = 1'b0;
    int burst_left = 0;
    t_stall_style stall_style = STALL_NONE;
    int stall_phase = 0;

    text_console_cell_writer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- prediction

    function automatic int unsigned sat_down(int unsigned a, int unsigned b);
        return (a > b) ? a - b : 0;
    endfunction

    function automatic int unsigned sat_up(int unsigned a, int unsigned b);
        return (a + b > LAST_CELL) ? LAST_CELL : a + b;
    endfunction

    function automatic int unsigned cell_index(logic [COL_W-1:0] col, logic [ROW_W-1:0] rw);
        int unsigned p;
        p = int'(col) + int'(rw) * COLUMNS;
        return (p > LAST_CELL) ? LAST_CELL : p;
    endfunction

    function automatic void blank_all();
        for (int i = 0; i < CELLS; i++)
            shadow_cells[i] = BLANK;
    endfunction

    function automatic void track_hw();
        if (regs_now.cursor_follow)
            shadow_hw = shadow_cursor;
    endfunction

    // move every row up one and blank the bottom row
    function automatic void shift_up();
        for (int i = 0; i < CELLS - COLUMNS; i++)
            shadow_cells[i] = shadow_cells[i + COLUMNS];
        for (int i = SCROLL_AT; i < CELLS; i++)
            shadow_cells[i] = BLANK;
        shadow_cursor = sat_down(shadow_cursor, COLUMNS);
        track_hw();
    endfunction

    // one character at the cursor, returns the cell written or zero
    function automatic logic [CELL_W-1:0] write_char(logic [CHAR_W-1:0] ch, output bit scr);
        logic [CELL_W-1:0] v;
        scr = 1'b0;
        if (shadow_cursor > LAST_CELL)
            shadow_cursor = LAST_CELL;
        if (ch == CODE_BS) begin
            shadow_cursor = sat_down(shadow_cursor, 1);
            shadow_cells[shadow_cursor] = BLANK;
            track_hw();
            return BLANK;
        end
        if (ch == CODE_NL) begin
            shadow_cursor = sat_up(shadow_cursor - shadow_cursor % COLUMNS, COLUMNS);
            track_hw();
            return '0;
        end
        if (ch == CODE_CR) begin
            shadow_cursor = shadow_cursor - shadow_cursor % COLUMNS;
            track_hw();
            return '0;
        end
        if (ch == regs_now.left_code) begin
            shadow_cursor = sat_down(shadow_cursor, 1);
            track_hw();
            return '0;
        end
        if (ch == regs_now.right_code) begin
            shadow_cursor = sat_up(shadow_cursor, 1);
            track_hw();
            return '0;
        end
        if (ch == regs_now.up_code) begin
            shadow_cursor = sat_down(shadow_cursor, COLUMNS);
            track_hw();
            return '0;
        end
        if (ch == regs_now.down_code) begin
            shadow_cursor = sat_up(shadow_cursor, COLUMNS);
            track_hw();
            return '0;
        end
        v = {regs_now.text_color, ch};
        shadow_cells[shadow_cursor] = v;
        shadow_cursor = sat_up(shadow_cursor, 1);
        track_hw();
        if (shadow_cursor >= SCROLL_AT) begin
            shift_up();
            scr = 1'b1;
        end
        return v;
    endfunction

    function automatic t_out console_step(t_in it);
        t_out r;
        int unsigned saved;
        bit scr;
        logic [CELL_W-1:0] cell_v;
        cell_v = '0;
        scr = 1'b0;
        case (it.mode)
            MODE_CHAR: cell_v = write_char(it.char_code, scr);
            MODE_AT: begin
                saved = shadow_cursor;
                shadow_cursor = cell_index(it.column, it.row);
                cell_v = write_char(it.char_code, scr);
                shadow_cursor = saved;
                track_hw();
            end
            MODE_SET: shadow_cursor = cell_index(it.column, it.row);
            MODE_CLEAR: begin
                blank_all();
                shadow_cursor = 0;
            end
            MODE_READ: cell_v = shadow_cells[cell_index(it.column, it.row)];
            default: ;
        endcase
        r.cursor_pos = POS_W'(shadow_cursor);
        r.hw_cursor_pos = POS_W'(shadow_hw);
        r.cell_value = cell_v;
        r.scrolled = scr;
        return r;
    endfunction

    initial blank_all();

    // ---------------------------------------------------------------- driving

    function automatic t_in cmd(logic [MODE_W-1:0] m, logic [CHAR_W-1:0] ch,
                                logic [COL_W-1:0] col, logic [ROW_W-1:0] rw);
        t_in it;
        it.mode = m;
        it.char_code = ch;
        it.column = col;
        it.row = rw;
        return it;
    endfunction

    // send one transaction; valid stays up while a burst goes on
    task automatic send_cmd(t_in item);
        if (!in_busy) begin
            repeat (sender_gaps ? $urandom_range(1, 6) : 1) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        in_busy = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        expected_screen_q.push_back(console_step(item));
        if (sender_gaps) begin
            burst_left--;
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                in_busy = 1'b0;
            end
        end
    endtask

    // stop sending and wait until every result is back and the block is free
    task automatic drain_console();
        if (in_busy) begin
            i_in_valid <= 1'b0;
            in_busy = 1'b0;
        end
        while (expected_screen_q.size() != 0) @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // write all registers back to back
    task automatic program_regs(t_cfg c);
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] dat;
        for (int k = 0; k < NUM_REGS; k++) begin
            case (k)
                0: begin idx = CFG_TEXT_COLOR; dat = c.text_color; end
                1: begin
                    idx = CFG_CURSOR_FOLLOW;
                    dat = 8'($urandom);
                    dat[0] = c.cursor_follow;
                end
                2: begin idx = CFG_LEFT_CODE; dat = c.left_code; end
                3: begin idx = CFG_RIGHT_CODE; dat = c.right_code; end
                4: begin idx = CFG_UP_CODE; dat = c.up_code; end
                default: begin idx = CFG_DOWN_CODE; dat = c.down_code; end
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= dat;
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx)
                CFG_TEXT_COLOR: regs_now.text_color = dat;
                CFG_CURSOR_FOLLOW: regs_now.cursor_follow = dat[0];
                CFG_LEFT_CODE: regs_now.left_code = dat;
                CFG_RIGHT_CODE: regs_now.right_code = dat;
                CFG_UP_CODE: regs_now.up_code = dat;
                default: regs_now.down_code = dat;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // mostly printable text, some control and arrow codes, some anything
    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 8'($urandom_range(8'h20, 8'h7e));
            6: case ($urandom_range(0, 2))
                0: return CODE_BS;
                1: return CODE_NL;
                default: return CODE_CR;
            endcase
            7: case ($urandom_range(0, 3))
                0: return regs_now.left_code;
                1: return regs_now.right_code;
                2: return regs_now.up_code;
                default: return regs_now.down_code;
            endcase
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_in random_item();
        t_in it;
        int unsigned pick;
        it.char_code = pick_char();
        it.column = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, COLUMNS - 1));
        it.row = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, ROWS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 55)
            it.mode = MODE_CHAR;
        else if (pick < 67)
            it.mode = MODE_AT;
        else if (pick < 75)
            it.mode = MODE_SET;
        else if (pick < 77)
            it.mode = MODE_CLEAR;
        else if (pick < 95)
            it.mode = MODE_READ;
        else
            it.mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        return it;
    endfunction

    // ---------------------------------------------------------------- receiver and checks

    // output stall follows its own changing pattern
    always @(posedge i_clk) begin
        if (stall_phase == 0) begin
            stall_style <= t_stall_style'($urandom_range(0, 3));
            stall_phase <= $urandom_range(20, 120);
        end else begin
            stall_phase <= stall_phase - 1;
        end
        case (stall_style)
            STALL_NONE: i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: i_out_stall <= (stall_phase % 5 < 2);
            default: i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic flag_mismatch(string what, int unsigned exp_v, int unsigned got_v);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t %s mismatch: expected 0x%0h actual 0x%0h", $time, what, exp_v, got_v);
    endtask

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_screen_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t unexpected result: expected none actual 0x%0h",
                             $time, o_out_data);
            end else begin
                want = expected_screen_q.pop_front();
                if (o_out_data.cursor_pos !== want.cursor_pos)
                    flag_mismatch("cursor_pos", want.cursor_pos, o_out_data.cursor_pos);
                if (o_out_data.hw_cursor_pos !== want.hw_cursor_pos)
                    flag_mismatch("hw_cursor_pos", want.hw_cursor_pos, o_out_data.hw_cursor_pos);
                if (o_out_data.cell_value !== want.cell_value)
                    flag_mismatch("cell_value", want.cell_value, o_out_data.cell_value);
                if (o_out_data.scrolled !== want.scrolled)
                    flag_mismatch("scrolled", want.scrolled, o_out_data.scrolled);
            end
        end
    end

    // cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("FAIL text_console_cell_writer");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    // registers written with their reset values during the power-up sweep
    task automatic test_power_up();
        program_regs(regs_now);
        drain_console();
    endtask

    // edges of the cursor, control codes, scrolls, position saturation, unused modes
    task automatic test_directed();
        send_cmd(cmd(MODE_CHAR, 8'h48, 7'd0, 5'd0));
        send_cmd(cmd(MODE_CHAR, 8'h00, 7'd127, 5'd31));
        send_cmd(cmd(MODE_CHAR, 8'hff, 7'd0, 5'd0));
        send_cmd(cmd(MODE_CHAR, CODE_BS, 7'd0, 5'd0));
        send_cmd(cmd(MODE_CHAR, CODE_CR, 7'd0, 5'd0));
        // backspace at the first cell stays there
        send_cmd(cmd(MODE_CHAR, CODE_BS, 7'd0, 5'd0));
        send_cmd(cmd(MODE_CHAR, regs_now.left_code, 7'd0, 5'd0));
        send_cmd(cmd(MODE_CHAR, regs_now.up_code, 7'd0, 5'd0));
        send_cmd(cmd(MODE_CHAR, regs_now.right_code, 7'd0, 5'd0));
        send_cmd(cmd(MODE_CHAR, regs_now.down_code, 7'd0, 5'd0));
        send_cmd(cmd(MODE_CHAR, CODE_NL, 7'd0, 5'd0));
        // out of range position saturates to the last cell, hw cursor untouched
        send_cmd(cmd(MODE_SET, 8'h00, 7'd127, 5'd31));
        send_cmd(cmd(MODE_CHAR, regs_now.right_code, 7'd0, 5'd0));
        send_cmd(cmd(MODE_CHAR, regs_now.down_code, 7'd0, 5'd0));
        // newline in the last row does not scroll
        send_cmd(cmd(MODE_CHAR, CODE_NL, 7'd0, 5'd0));
        send_cmd(cmd(MODE_CHAR, 8'h5a, 7'd0, 5'd0));
        send_cmd(cmd(MODE_READ, 8'h00, 7'd79, 5'd23));
        // write at a position that scrolls, cursor restored afterwards
        send_cmd(cmd(MODE_AT, 8'h51, 7'd79, 5'd23));
        send_cmd(cmd(MODE_AT, 8'h71, 7'd127, 5'd0));
        send_cmd(cmd(MODE_READ, 8'h00, 7'd127, 5'd31));
        send_cmd(cmd(MODE_CLEAR, 8'hff, 7'd127, 5'd31));
        send_cmd(cmd(MODE_READ, 8'h00, 7'd0, 5'd0));
        for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
            send_cmd(cmd(MODE_W'(m), 8'($urandom), 7'($urandom), 5'($urandom)));
        drain_console();
    endtask

    // arrow registers holding control codes lose to the control meaning
    task automatic test_code_overlap();
        t_cfg c;
        c = '{text_color: 8'ha5, cursor_follow: 1'b1, left_code: CODE_BS,
              right_code: CODE_NL, up_code: CODE_CR, down_code: 8'h41};
        program_regs(c);
        send_cmd(cmd(MODE_SET, 8'h00, 7'd5, 5'd3));
        send_cmd(cmd(MODE_CHAR, CODE_BS, 7'd0, 5'd0));
        send_cmd(cmd(MODE_CHAR, CODE_NL, 7'd0, 5'd0));
        send_cmd(cmd(MODE_CHAR, CODE_CR, 7'd0, 5'd0));
        send_cmd(cmd(MODE_CHAR, 8'h41, 7'd0, 5'd0));
        send_cmd(cmd(MODE_CHAR, 8'h42, 7'd0, 5'd0));
        drain_console();
    endtask

    // random traffic under several register settings, extremes included
    task automatic test_random_phases();
        t_cfg c;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: c = '{8'h1e, 1'b1, 8'd128, 8'd129, 8'd130, 8'd131};
                1: c = '{8'h00, 1'b0, 8'h00, 8'hff, 8'h7f, 8'h80};
                2: c = '{8'hff, 1'b1, 8'hff, 8'h00, 8'h1b, 8'h20};
                3: c = '{8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom)};
                4: c = '{8'($urandom), 1'b0, 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom)};
                default: c = '{8'd15, 1'b1, 8'd128, 8'd129, 8'd130, 8'd131};
            endcase
            program_regs(c);
            // one phase with the sender never idling
            sender_gaps = (p != 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_cmd(random_item());
            drain_console();
        end
        sender_gaps = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_power_up();
        test_directed();
        test_code_overlap();
        test_random_phases();
        drain_console();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("PASS text_console_cell_writer");
        else
            $display("FAIL text_console_cell_writer");
        $finish;
    end

endmodule

[files.f]
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_cfg.sv
rtl/core/tcw_rowsplit.sv
rtl/core/tcw_char.sv
rtl/core/text_console_cell_writer.sv
rtl/core/tcw_checker.sv
test/text_console_cell_writer_tb.sv
